// File: design/ffpa_pkg.sv
package ffpa_pkg;

    localparam int SIZE_W  = 14;
    localparam int UNITS_W = 8;
    localparam int PIU_W   = 7;
    localparam int QUO_W   = SIZE_W + 1;
    localparam int PID_W   = 8;
    localparam int FIRST_W = 6;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;
    localparam int WIDE_W  = 16;

    localparam logic [PIU_W-1:0]   PIU_RESET   = 7'd64;
    localparam logic [UNITS_W-1:0] UNITS_RESET = 8'd16;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_PAGES = 1'b0;
    localparam logic CFG_UNITS = 1'b1;

    localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STAT_W-1:0] ST_CANNOT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREED     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SEARCH,
        S_MARK,
        S_FREE
    } t_state;

    typedef struct packed {
        logic start;
        logic [QUO_W-1:0] dividend;
        logic [UNITS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: design/ffpa_cell.sv
module ffpa_cell #(
    parameter int ID_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic [ID_BITS-1:0] i_owner,
    output logic [ID_BITS-1:0] o_owner
);

    logic [ID_BITS-1:0] r_owner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
        end else if (i_shift) begin
            r_owner <= i_owner;
        end
    end

    assign o_owner = r_owner;

endmodule

// File: design/ffpa_div.sv
module ffpa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffpa_pkg::t_div_req i_req,
    output ffpa_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(ffpa_pkg::QUO_W + 1);

    logic [ffpa_pkg::UNITS_W:0]   r_rem;
    logic [ffpa_pkg::QUO_W-1:0]   r_quo;
    logic [ffpa_pkg::UNITS_W-1:0] r_div;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [ffpa_pkg::UNITS_W:0]   trial;
    logic                         ge;

    assign trial = {r_rem[ffpa_pkg::UNITS_W-1:0], r_quo[ffpa_pkg::QUO_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ffpa_pkg::QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? trial - {1'b0, r_div} : trial;
            r_quo <= {r_quo[ffpa_pkg::QUO_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: design/first_fit_page_allocator_core.sv
// First-fit contiguous page allocator.
// Command channel: an item is taken at a clock edge with start high and busy low.
// Allocate (command 0) marks the lowest free run of ceil(request_size /
// units_per_page) pages with process_id; free (command 1) clears every page
// that process_id owns. Each item gives one result on o_status, o_first_page
// and o_page_count, marked by o_valid for exactly one cycle.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 = pages in use, 1 = units per page) at once; write only while idle.
// Allocate runs the bit-serial divider, then one full turn of the page ring
// to search and one more to mark. Free takes one ring turn.
// Rejected allocates (zero id, zero size, zero units, zero pages in use)
// answer in the cycle after they are taken; a run longer than the pages in
// use is refused once the divider finishes.
// The ring turns one page per cycle past a single head cell; that sets the rate.
// One item at a time; busy stays high until its result is issued and drops
// in the cycle the strobe shows. The receiver cannot stall.
// Reset clears every page to free and loads 64 pages of 16 units.
module first_fit_page_allocator_core #(
    parameter int MAX_PAGES = 64,
    parameter int ID_BITS   = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_command,
    input  logic [ffpa_pkg::PID_W-1:0]        i_process_id,
    input  logic [ffpa_pkg::SIZE_W-1:0]       i_request_size,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [ffpa_pkg::UNITS_W-1:0]      i_cfg_data,
    output logic                              o_valid,
    output logic [ffpa_pkg::STAT_W-1:0]       o_status,
    output logic [ffpa_pkg::FIRST_W-1:0]      o_first_page,
    output logic [ffpa_pkg::COUNT_W-1:0]      o_page_count
);

    localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int LIM_W = $clog2(MAX_PAGES + 1);
    localparam int WW    = ffpa_pkg::WIDE_W;

    ffpa_pkg::t_state r_state, n_state;

    logic [PW-1:0]                 r_pos, n_pos;
    logic [LIM_W-1:0]              r_run, n_run;
    logic [LIM_W-1:0]              r_count, n_count;
    logic [ffpa_pkg::QUO_W-1:0]    r_need, n_need;
    logic [PW-1:0]                 r_start_pg, n_start_pg;
    logic                          r_found, n_found;
    logic [ID_BITS-1:0]            r_id, n_id;
    logic                          r_valid, n_valid;
    logic [ffpa_pkg::STAT_W-1:0]   r_status, n_status;
    logic [ffpa_pkg::FIRST_W-1:0]  r_first, n_first;
    logic [ffpa_pkg::COUNT_W-1:0]  r_pcount, n_pcount;
    logic [ffpa_pkg::PIU_W-1:0]    r_piu;
    logic [ffpa_pkg::UNITS_W-1:0]  r_upp;

    logic [ID_BITS-1:0]            chain [MAX_PAGES];
    logic [ID_BITS-1:0]            head;
    logic [ID_BITS-1:0]            head_new;
    logic                          shift;

    logic                          accept;
    logic [WW-1:0]                 pid_wide;
    logic [ID_BITS-1:0]            in_id;
    logic [WW-1:0]                 limit_wide;
    logic [LIM_W-1:0]              limit;
    logic                          reject;
    logic                          pos_last;
    logic                          pos_in;
    logic [WW-1:0]                 run_p1;
    logic                          hit;
    logic                          in_run;
    logic                          match;

    ffpa_pkg::t_div_req            div_req;
    ffpa_pkg::t_div_rsp            div_rsp;

    assign accept     = start && !busy;
    assign busy       = r_state != ffpa_pkg::S_IDLE;
    assign pid_wide   = WW'(i_process_id);
    assign in_id      = pid_wide[ID_BITS-1:0];
    assign limit_wide = (WW'(r_piu) > WW'(MAX_PAGES)) ? WW'(MAX_PAGES) : WW'(r_piu);
    assign limit      = limit_wide[LIM_W-1:0];
    assign reject     = (in_id == '0) || (i_request_size == '0) || (r_upp == '0)
                        || (limit == '0);

    assign head     = chain[0];
    assign pos_last = r_pos == PW'(MAX_PAGES - 1);
    assign pos_in   = WW'(r_pos) < WW'(limit);
    assign run_p1   = WW'(r_run) + WW'(1);
    assign hit      = !r_found && pos_in && (head == '0) && (run_p1 == WW'(r_need));
    assign in_run   = (WW'(r_pos) >= WW'(r_start_pg))
                      && (WW'(r_pos) < WW'(r_start_pg) + WW'(r_need));
    assign match    = (r_id != '0) && (head == r_id);

    assign shift = (r_state == ffpa_pkg::S_SEARCH) || (r_state == ffpa_pkg::S_MARK)
                   || (r_state == ffpa_pkg::S_FREE);

    always_comb begin
        head_new = head;
        if (r_state == ffpa_pkg::S_MARK && in_run) begin
            head_new = r_id;
        end else if (r_state == ffpa_pkg::S_FREE && match) begin
            head_new = '0;
        end
    end

    for (genvar k = 0; k < MAX_PAGES; k++) begin : g_ring
        ffpa_cell #(
            .ID_BITS(ID_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_owner ((k == MAX_PAGES - 1) ? head_new : chain[(k + 1) % MAX_PAGES]),
            .o_owner (chain[k])
        );
    end

    assign div_req.start    = accept && (i_command == ffpa_pkg::CMD_ALLOC) && !reject;
    assign div_req.dividend = ffpa_pkg::QUO_W'(i_request_size) + ffpa_pkg::QUO_W'(r_upp)
                              - ffpa_pkg::QUO_W'(1);
    assign div_req.divisor  = r_upp;

    ffpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            ffpa_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_command == ffpa_pkg::CMD_FREE) begin
                        n_state = ffpa_pkg::S_FREE;
                    end else if (!reject) begin
                        n_state = ffpa_pkg::S_DIV;
                    end
                end
            end
            ffpa_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    n_state = (WW'(div_rsp.quotient) > WW'(limit)) ? ffpa_pkg::S_IDLE
                                                                   : ffpa_pkg::S_SEARCH;
                end
            end
            ffpa_pkg::S_SEARCH: begin
                if (pos_last) begin
                    n_state = (r_found || hit) ? ffpa_pkg::S_MARK : ffpa_pkg::S_IDLE;
                end
            end
            ffpa_pkg::S_MARK, ffpa_pkg::S_FREE: begin
                if (pos_last) begin
                    n_state = ffpa_pkg::S_IDLE;
                end
            end
            default: n_state = ffpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_pos      = shift ? (pos_last ? '0 : r_pos + 1'b1) : r_pos;
        n_run      = r_run;
        n_count    = r_count;
        n_need     = r_need;
        n_start_pg = r_start_pg;
        n_found    = r_found;
        n_id       = r_id;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_first    = r_first;
        n_pcount   = r_pcount;
        unique case (r_state)
            ffpa_pkg::S_IDLE: begin
                n_pos   = '0;
                n_run   = '0;
                n_count = '0;
                n_found = 1'b0;
                if (accept) begin
                    n_id = in_id;
                    if (i_command == ffpa_pkg::CMD_ALLOC && reject) begin
                        n_valid  = 1'b1;
                        n_status = ffpa_pkg::ST_CANNOT;
                        n_first  = '0;
                        n_pcount = '0;
                    end
                end
            end
            ffpa_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    n_need = div_rsp.quotient;
                    if (WW'(div_rsp.quotient) > WW'(limit)) begin
                        n_valid  = 1'b1;
                        n_status = ffpa_pkg::ST_CANNOT;
                        n_first  = '0;
                        n_pcount = '0;
                    end
                end
            end
            ffpa_pkg::S_SEARCH: begin
                if (!r_found) begin
                    n_run = (pos_in && head == '0) ? run_p1[LIM_W-1:0] : '0;
                end
                if (hit) begin
                    n_found    = 1'b1;
                    n_start_pg = PW'(WW'(r_pos) + WW'(1) - WW'(r_need));
                end
                if (pos_last && !(r_found || hit)) begin
                    n_valid  = 1'b1;
                    n_status = ffpa_pkg::ST_CANNOT;
                    n_first  = '0;
                    n_pcount = '0;
                end
            end
            ffpa_pkg::S_MARK: begin
                if (pos_last) begin
                    n_valid  = 1'b1;
                    n_status = ffpa_pkg::ST_ALLOCATED;
                    n_first  = ffpa_pkg::FIRST_W'(r_start_pg);
                    n_pcount = ffpa_pkg::COUNT_W'(r_need);
                end
            end
            ffpa_pkg::S_FREE: begin
                if (match) begin
                    n_count = r_count + 1'b1;
                end
                if (pos_last) begin
                    n_valid  = 1'b1;
                    n_status = ffpa_pkg::ST_FREED;
                    n_first  = '0;
                    n_pcount = ffpa_pkg::COUNT_W'(match ? r_count + 1'b1 : r_count);
                end
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffpa_pkg::S_IDLE;
            r_pos   <= '0;
            r_run   <= '0;
            r_count <= '0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
            r_piu   <= ffpa_pkg::PIU_RESET;
            r_upp   <= ffpa_pkg::UNITS_RESET;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_run   <= n_run;
            r_count <= n_count;
            r_found <= n_found;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ffpa_pkg::CFG_PAGES: r_piu <= i_cfg_data[ffpa_pkg::PIU_W-1:0];
                    ffpa_pkg::CFG_UNITS: r_upp <= i_cfg_data;
                    default: r_upp <= r_upp;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need     <= n_need;
        r_start_pg <= n_start_pg;
        r_id       <= n_id;
        r_status   <= n_status;
        r_first    <= n_first;
        r_pcount   <= n_pcount;
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_first_page = r_first;
    assign o_page_count = r_pcount;

    a_valid_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || $past(start)))
        else $error("result without a command");

    a_mark_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffpa_pkg::S_MARK) |-> (WW'(r_need) <= WW'(limit)))
        else $error("marking a run longer than the pages in use");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ffpa_pkg::S_DIV))
        else $error("divider finished outside the divide phase");

    a_cannot_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ffpa_pkg::ST_CANNOT)
            |-> (o_page_count == '0 && o_first_page == '0))
        else $error("refused allocation reports pages");

endmodule
